// ===== hw/rtl/chi2_nearest_cluster_match_defines.svh =====
// Assertion macros shared by the chi2 cluster matcher RTL.
// Each macro expects the including module to have clk and arst_n in scope.
`ifndef CHI2_NEAREST_CLUSTER_MATCH_DEFINES_SVH
`define CHI2_NEAREST_CLUSTER_MATCH_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define C2M_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define C2M_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/c2m_pkg.sv =====
// Shared types and constants for the chi2 nearest cluster matcher.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package c2m_pkg;

	// Chi2 values are unsigned Q20.8 and saturate at full scale.
	localparam int ChiW = 28;
	localparam logic [ChiW-1:0] ChiSat = {ChiW{1'b1}};
	// The cap 1e6 in Q20.8.
	localparam logic [ChiW-1:0] ChiCap = 28'd256000000;

	localparam int OutIdxW = 10;
	localparam int MaxClustersDef = 1024;

	// Configuration port.
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TIME_OFFSET    = 3'd0,
		REG_INV_SIGMA_TIME = 3'd1,
		REG_INV_SIGMA_X    = 3'd2,
		REG_INV_SIGMA_Y    = 3'd3,
		REG_BEST_ONLY      = 3'd4
	} cfg_reg_e;

	localparam logic signed [13:0] TimeOffsetRst = 14'sd0;
	localparam logic [15:0] InvSigmaRst = 16'd256;
	localparam logic BestOnlyRst = 1'b1;

	// Which chi2 term the shared multiplier works on.
	typedef enum logic [1:0] {
		TERM_TIME = 2'd0,
		TERM_X    = 2'd1,
		TERM_Y    = 2'd2
	} term_e;

	// Multiplier phase: scale the residual, then square the scaled value.
	typedef enum logic {
		PH_SCALE  = 1'b0,
		PH_SQUARE = 1'b1
	} phase_e;

	// Input beat.
	typedef struct packed {
		logic [7:0]         track_tag;
		logic signed [15:0] track_x;
		logic signed [15:0] track_y;
		logic [16:0]        track_time;
		logic signed [15:0] cluster_x;
		logic signed [15:0] cluster_y;
		logic [16:0]        cluster_time;
		logic               last_cluster;
	} in_item_t;

	// Output beat.
	typedef struct packed {
		logic [7:0]         match_tag;
		logic [OutIdxW-1:0] cluster_index;
		logic [ChiW-1:0]    chi2_total;
		logic [ChiW-1:0]    chi2_time;
		logic [ChiW-1:0]    chi2_position;
		logic               is_last;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic   capture;
		logic   mul_en;
		phase_e phase;
		term_e  term;
		logic   add_pos;
		logic   add_total;
		logic   commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic emit;
	} dp_stat_t;

endpackage

// ===== hw/rtl/c2m_datapath.sv =====
// Datapath of the chi2 matcher: config registers, shared multiplier, term and
// best-match registers, output beat register. Depends on c2m_pkg and the defines header.
`timescale 1ns / 1ps
`include "chi2_nearest_cluster_match_defines.svh"

module c2m_datapath
	import c2m_pkg::*;
#(
	parameter int MAX_CLUSTERS = MaxClustersDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  in_item_t            in_data,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	output out_item_t           out_data
);

	localparam int CntW = $clog2(MAX_CLUSTERS);
	localparam logic [CntW-1:0] CntMax = CntW'(MAX_CLUSTERS - 1);

	// Saturating add of two chi2 values.
	function automatic logic [ChiW-1:0] sat_add(input logic [ChiW-1:0] a,
			input logic [ChiW-1:0] b);
		logic [ChiW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ChiW] ? ChiSat : s[ChiW-1:0];
	endfunction

	// Configuration registers.
	logic signed [13:0] time_offset_q;
	logic [15:0]        inv_sigma_time_q;
	logic [15:0]        inv_sigma_x_q;
	logic [15:0]        inv_sigma_y_q;
	logic               best_only_q;

	// Captured item.
	logic [17:0] mag_t_q, mag_x_q, mag_y_q;
	logic [7:0]  tag_q;
	logic        last_q;

	// Terms and sums.
	logic [35:0]     prod_q;
	logic [ChiW-1:0] term_t_q, term_x_q, term_y_q;
	logic [ChiW-1:0] pos_q, total_q;

	// Run state.
	logic [ChiW-1:0] best_chi2_q, best_tt_q, best_tp_q;
	logic [CntW-1:0] best_idx_q, count_q;

	out_item_t out_q;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_offset_q    <= TimeOffsetRst;
			inv_sigma_time_q <= InvSigmaRst;
			inv_sigma_x_q    <= InvSigmaRst;
			inv_sigma_y_q    <= InvSigmaRst;
			best_only_q      <= BestOnlyRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIME_OFFSET:    time_offset_q    <= signed'(cfg_data[13:0]);
				REG_INV_SIGMA_TIME: inv_sigma_time_q <= cfg_data;
				REG_INV_SIGMA_X:    inv_sigma_x_q    <= cfg_data;
				REG_INV_SIGMA_Y:    inv_sigma_y_q    <= cfg_data;
				REG_BEST_ONLY:      best_only_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Residual magnitudes of the incoming beat.
	logic [18:0] dt, dt_neg;
	logic [16:0] dx, dx_neg, dy, dy_neg;
	logic [17:0] mag_t, mag_x, mag_y;

	always_comb begin
		dt = {2'b00, in_data.cluster_time} - {2'b00, in_data.track_time}
			- {{5{time_offset_q[13]}}, time_offset_q};
		dt_neg = ~dt + 19'd1;
		mag_t = dt[18] ? dt_neg[17:0] : dt[17:0];
		dx = {in_data.cluster_x[15], in_data.cluster_x} - {in_data.track_x[15], in_data.track_x};
		dx_neg = ~dx + 17'd1;
		mag_x = {2'b00, dx[16] ? dx_neg[15:0] : dx[15:0]};
		dy = {in_data.cluster_y[15], in_data.cluster_y} - {in_data.track_y[15], in_data.track_y};
		dy_neg = ~dy + 17'd1;
		mag_y = {2'b00, dy[16] ? dy_neg[15:0] : dy[15:0]};
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mag_t_q <= mag_t;
			mag_x_q <= mag_x;
			mag_y_q <= mag_y;
			tag_q   <= in_data.track_tag;
			last_q  <= in_data.last_cluster;
		end
	end

	// Shared multiplier operands: residual times inverse sigma, then the square.
	logic [17:0] mul_a, mul_b;
	logic [35:0] prod;
	logic [ChiW-1:0] term_val;

	always_comb begin
		mul_a = prod_q[17:0];
		mul_b = prod_q[17:0];
		if (cmd.phase == PH_SCALE) begin
			unique case (cmd.term)
				TERM_TIME: begin
					mul_a = mag_t_q;
					mul_b = {2'b00, inv_sigma_time_q};
				end
				TERM_X: begin
					mul_a = mag_x_q;
					mul_b = {2'b00, inv_sigma_x_q};
				end
				TERM_Y: begin
					mul_a = mag_y_q;
					mul_b = {2'b00, inv_sigma_y_q};
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
		prod = mul_a * mul_b;
		// A scaled value of 2^18 or more saturates the term.
		term_val = (|prod_q[35:18]) ? ChiSat : prod[35:8];
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			if (cmd.phase == PH_SCALE) begin
				prod_q <= prod;
			end else begin
				unique case (cmd.term)
					TERM_TIME: term_t_q <= term_val;
					TERM_X:    term_x_q <= term_val;
					TERM_Y:    term_y_q <= term_val;
					default: ;
				endcase
			end
		end
		if (cmd.add_pos) begin
			pos_q <= sat_add(term_x_q, term_y_q);
		end
		if (cmd.add_total) begin
			total_q <= sat_add(term_t_q, pos_q);
		end
	end

	// Running minimum update.
	logic            lt, first, take_terms;
	logic [ChiW-1:0] nb_chi2, nb_tt, nb_tp;
	logic [CntW-1:0] nb_idx;
	logic [CntW+OutIdxW-1:0] cur_idx_ext, nb_idx_ext;

	always_comb begin
		lt = total_q < best_chi2_q;
		first = (count_q == '0);
		take_terms = lt | first;
		nb_chi2 = lt ? total_q : best_chi2_q;
		nb_idx = lt ? count_q : (first ? '0 : best_idx_q);
		nb_tt = take_terms ? term_t_q : best_tt_q;
		nb_tp = take_terms ? pos_q : best_tp_q;
		cur_idx_ext = {{OutIdxW{1'b0}}, count_q};
		nb_idx_ext = {{OutIdxW{1'b0}}, nb_idx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_chi2_q <= ChiCap;
			best_idx_q  <= '0;
			best_tt_q   <= '0;
			best_tp_q   <= '0;
			count_q     <= '0;
		end else if (cmd.commit) begin
			if (last_q) begin
				best_chi2_q <= ChiCap;
				best_idx_q  <= '0;
				best_tt_q   <= '0;
				best_tp_q   <= '0;
				count_q     <= '0;
			end else begin
				best_chi2_q <= nb_chi2;
				best_idx_q  <= nb_idx;
				best_tt_q   <= nb_tt;
				best_tp_q   <= nb_tp;
				if (count_q < CntMax) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// Output beat register, loaded only when a result is due.
	always_ff @(posedge clk) begin
		if (cmd.commit && stat.emit) begin
			out_q.match_tag <= tag_q;
			if (best_only_q) begin
				out_q.cluster_index <= nb_idx_ext[OutIdxW-1:0];
				out_q.chi2_total    <= nb_chi2;
				out_q.chi2_time     <= nb_tt;
				out_q.chi2_position <= nb_tp;
				out_q.is_last       <= 1'b1;
			end else begin
				out_q.cluster_index <= cur_idx_ext[OutIdxW-1:0];
				out_q.chi2_total    <= total_q;
				out_q.chi2_time     <= term_t_q;
				out_q.chi2_position <= pos_q;
				out_q.is_last       <= last_q;
			end
		end
	end

	assign stat.emit = ~best_only_q | last_q;
	assign out_data = out_q;

	`C2M_ASSERT_NOW(a_best_under_cap, 1'b1, best_chi2_q <= ChiCap, "best chi2 above cap")
	`C2M_ASSERT_NOW(a_count_bounded, 1'b1, count_q <= CntMax, "cluster count overran")
	`C2M_ASSERT_NEXT(a_run_cleared, cmd.commit && last_q,
		count_q == '0 && best_chi2_q == ChiCap, "run state not cleared after last cluster")

endmodule

// ===== hw/rtl/c2m_ctrl.sv =====
// Controller of the chi2 matcher: sequences the shared multiplier, the sums
// and the commit, and owns the output valid flag. Depends on c2m_pkg and the defines header.
`timescale 1ns / 1ps
`include "chi2_nearest_cluster_match_defines.svh"

module c2m_ctrl
	import c2m_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD_POS,
		ST_ADD_TOT,
		ST_COMMIT
	} state_e;

	// Three terms, two multiplier passes each.
	localparam logic [2:0] LastStep = 3'd5;

	state_e     state_q;
	logic [2:0] step_q;
	logic       out_valid_q;
	logic       accept, commit_go;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid & in_ready;
	// A result that loads the output register is only committed once that register is free or being taken.
	assign commit_go = (state_q == ST_COMMIT) && (!stat.emit || !out_valid_q || out_ready);

	// Command decode.
	always_comb begin
		cmd.capture = accept;
		cmd.mul_en = (state_q == ST_MUL);
		cmd.phase = phase_e'(step_q[0]);
		cmd.term = term_e'(step_q[2:1]);
		cmd.add_pos = (state_q == ST_ADD_POS);
		cmd.add_total = (state_q == ST_ADD_TOT);
		cmd.commit = commit_go;
	end

	// State, step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit_go && stat.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (accept) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (step_q == LastStep) begin
						step_q <= '0;
						state_q <= ST_ADD_POS;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_ADD_POS: begin
					state_q <= ST_ADD_TOT;
				end
				ST_ADD_TOT: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (commit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	`C2M_ASSERT_NEXT(a_accept_starts_mul, accept, state_q == ST_MUL && step_q == 3'd0,
		"accepted beat did not start the multiplier sequence")
	`C2M_ASSERT_NEXT(a_commit_sets_valid, cmd.commit && stat.emit, out_valid_q,
		"committed result not presented")
	`C2M_ASSERT_NOW(a_valid_from_commit, $rose(out_valid_q), $past(state_q == ST_COMMIT),
		"output valid rose outside commit")
	`C2M_ASSERT_NOW(a_step_bounded, state_q == ST_MUL, step_q <= LastStep,
		"multiplier step out of range")

endmodule

// ===== hw/rtl/chi2_nearest_cluster_match.sv =====
// Top level of the chi2 nearest cluster matcher.
// Joins c2m_ctrl and c2m_datapath; depends on c2m_pkg.
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_data (in_item_t)
// out       output     out_valid / out_ready   out_data (out_item_t)
// cfg       input      cfg_we                  cfg_index, cfg_data
//
// A beat is accepted only while idle; its result is committed in the commit state,
// after six passes through the single shared 18x18 multiplier (scale and square for
// the time, x and y terms) and two saturating adds, and no new beat is accepted
// until that commit.
// The commit of an emitted result waits while a previous result is held and not taken.
// Reset clears the configuration to its defaults and the best-match run state.
`timescale 1ns / 1ps

module chi2_nearest_cluster_match
	import c2m_pkg::*;
#(
	parameter int MAX_CLUSTERS = MaxClustersDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer.
	c2m_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Arithmetic and state.
	c2m_datapath #(
		.MAX_CLUSTERS (MAX_CLUSTERS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule
